FILE: src/wsfd_pkg.sv
package wsfd_pkg;

    // Length codes carried in the 7-bit length field
    localparam logic [6:0] LEN_16BIT_CODE = 7'd126;
    localparam logic [6:0] LEN_64BIT_CODE = 7'd127;

    // Extended length byte counts
    localparam logic [3:0] EXT_LEN_16_BYTES = 4'd2;
    localparam logic [3:0] EXT_LEN_64_BYTES = 4'd8;

    // Mask key byte count
    localparam logic [2:0] KEY_BYTES = 3'd4;

    // One received byte of the frame stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    // One unmasked payload byte with its frame tags
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       frame_fin;
        logic       last_of_frame;
    } t_result;

endpackage

FILE: src/wsfd_if.sv
interface wsfd_byte_if import wsfd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface wsfd_payload_if import wsfd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic       last_of_frame;

    modport source (output valid, output payload_byte, output frame_opcode,
                    output frame_fin, output last_of_frame, input ready);
    modport sink   (input valid, input payload_byte, input frame_opcode,
                    input frame_fin, input last_of_frame, output ready);
endinterface

FILE: src/websocket_frame_deframer.sv
// WebSocket frame deframer: takes the received stream one byte per request, walks
// each frame header (FIN/opcode, mask bit and 7-bit length, optional 16- or 64-bit
// big-endian extended length, optional 4-byte mask key) and delivers every payload
// byte unmasked, tagged with the frame's opcode and FIN, with last_of_frame set on
// the final byte. Header bytes and empty frames deliver nothing; frame_start forces
// a restart at header byte 0. One byte is taken every cycle while the output side
// keeps up; a byte is held in the input register, then passes the parse-state
// update into the result register, from which it is shown. The parse state is
// updated once per consumed byte, which sets the one-byte-per-cycle figure.
module websocket_frame_deframer import wsfd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wsfd_byte_if.sink     i_in,
    wsfd_payload_if.source o_out
);

    t_in_item in_item;
    t_in_item held_item;
    logic     held_valid;
    logic     can_load;
    logic     advance;
    logic     res_valid;
    t_result  result;
    t_result  out_result;

    assign in_item.data_byte   = i_in.data_byte;
    assign in_item.frame_start = i_in.frame_start;

    // Consume the held byte when the result register has room
    assign advance = held_valid && can_load;

    wsfd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    wsfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_item      (held_item),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    wsfd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_result   (result),
        .o_can_load (can_load),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_result   (out_result)
    );

    assign o_out.payload_byte  = out_result.payload_byte;
    assign o_out.frame_opcode  = out_result.frame_opcode;
    assign o_out.frame_fin     = out_result.frame_fin;
    assign o_out.last_of_frame = out_result.last_of_frame;

endmodule

FILE: src/wsfd_in_stage.sv
module wsfd_in_stage import wsfd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Take a new request when empty or when the held one moves on
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Hold the accepted byte until the parser consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: src/wsfd_parser.sv
module wsfd_parser import wsfd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_advance,
    input  t_in_item i_item,
    output logic     o_res_valid,
    output t_result  o_result
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic [3:0]  r_opcode,       n_opcode;
    logic        r_fin,          n_fin;
    logic        r_masked,       n_masked;
    logic [3:0]  r_len_left,     n_len_left;
    logic [63:0] r_payload_left, n_payload_left;
    logic [31:0] r_key,          n_key;
    logic [2:0]  r_key_left,     n_key_left;
    logic [1:0]  r_key_pos,      n_key_pos;

    t_phase      phase;
    logic [6:0]  len7;
    logic [7:0]  key_byte;
    logic        last;

    // A set frame_start forces header byte 0
    assign phase = i_item.frame_start ? PH_HDR0 : r_phase;
    assign len7  = i_item.data_byte[6:0];
    assign last  = (r_payload_left == 64'd1);

    // Select the key byte for this payload position
    always_comb begin
        case (r_key_pos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
        if (!r_masked) begin
            key_byte = 8'd0;
        end
    end

    assign o_res_valid            = i_advance && (phase == PH_PAYLOAD);
    assign o_result.payload_byte  = i_item.data_byte ^ key_byte;
    assign o_result.frame_opcode  = r_opcode;
    assign o_result.frame_fin     = r_fin;
    assign o_result.last_of_frame = last;

    // Next parse state for the byte at hand
    always_comb begin
        n_phase        = r_phase;
        n_opcode       = r_opcode;
        n_fin          = r_fin;
        n_masked       = r_masked;
        n_len_left     = r_len_left;
        n_payload_left = r_payload_left;
        n_key          = r_key;
        n_key_left     = r_key_left;
        n_key_pos      = r_key_pos;
        unique case (phase)
            PH_HDR1: begin
                n_masked = i_item.data_byte[7];
                if (len7 == LEN_16BIT_CODE) begin
                    n_payload_left = 64'd0;
                    n_len_left     = EXT_LEN_16_BYTES;
                    n_phase        = PH_EXTLEN;
                end else if (len7 == LEN_64BIT_CODE) begin
                    n_payload_left = 64'd0;
                    n_len_left     = EXT_LEN_64_BYTES;
                    n_phase        = PH_EXTLEN;
                end else begin
                    n_len_left     = 4'd0;
                    n_payload_left = {57'd0, len7};
                    if (i_item.data_byte[7]) begin
                        n_key_left = KEY_BYTES;
                        n_key_pos  = 2'd0;
                        n_phase    = PH_KEY;
                    end else if (len7 == 7'd0) begin
                        n_phase = PH_HDR0;
                    end else begin
                        n_key_pos = 2'd0;
                        n_phase   = PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN: begin
                n_payload_left = {r_payload_left[55:0], i_item.data_byte};
                n_len_left     = r_len_left - 4'd1;
                if (r_len_left == 4'd1) begin
                    if (r_masked) begin
                        n_key_left = KEY_BYTES;
                        n_key_pos  = 2'd0;
                        n_phase    = PH_KEY;
                    end else if (n_payload_left == 64'd0) begin
                        n_phase = PH_HDR0;
                    end else begin
                        n_key_pos = 2'd0;
                        n_phase   = PH_PAYLOAD;
                    end
                end
            end
            PH_KEY: begin
                n_key      = {r_key[23:0], i_item.data_byte};
                n_key_left = r_key_left - 3'd1;
                if (r_key_left == 3'd1) begin
                    n_key_pos = 2'd0;
                    n_phase   = (r_payload_left == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_payload_left = r_payload_left - 64'd1;
                n_key_pos      = r_key_pos + 2'd1;
                if (last) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_fin          = i_item.data_byte[7];
                n_opcode       = i_item.data_byte[3:0];
                n_masked       = 1'b0;
                n_len_left     = 4'd0;
                n_payload_left = 64'd0;
                n_key_left     = 3'd0;
                n_key_pos      = 2'd0;
                n_phase        = PH_HDR1;
            end
        endcase
    end

    // Advance the parse state once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HDR0;
            r_opcode       <= 4'd0;
            r_fin          <= 1'b0;
            r_masked       <= 1'b0;
            r_len_left     <= 4'd0;
            r_payload_left <= 64'd0;
            r_key          <= 32'd0;
            r_key_left     <= 3'd0;
            r_key_pos      <= 2'd0;
        end else if (i_advance) begin
            r_phase        <= n_phase;
            r_opcode       <= n_opcode;
            r_fin          <= n_fin;
            r_masked       <= n_masked;
            r_len_left     <= n_len_left;
            r_payload_left <= n_payload_left;
            r_key          <= n_key;
            r_key_left     <= n_key_left;
            r_key_pos      <= n_key_pos;
        end
    end

endmodule

FILE: src/wsfd_out_stage.sv
module wsfd_out_stage import wsfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Room when empty or when the held result is taken this cycle
    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wsfd_pkg::*;

    // Parse phases of the expected-result model
    typedef enum logic [2:0] {
        ST_HDR0,
        ST_HDR1,
        ST_EXTLEN,
        ST_KEY,
        ST_PAYLOAD
    } t_parse_st;

    logic i_clk;
    logic i_rst_n;

    wsfd_byte_if    in_if ();
    wsfd_payload_if out_if ();

    websocket_frame_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Model copy of the parse state
    t_parse_st   pst;
    logic [3:0]  p_opcode;
    logic        p_fin;
    logic        p_masked;
    logic [3:0]  p_len_left;
    logic [63:0] p_remaining;
    logic [31:0] p_key;
    logic [2:0]  p_key_left;
    logic [1:0]  p_key_pos;

    t_result     pending_payload [$];
    int          mismatch_count;
    int          bytes_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;
    bit          need_restart;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Length is complete: move to the key, the payload or the next header
    function automatic void settle_length();
        if (p_masked) begin
            p_key_left = KEY_BYTES;
            p_key_pos  = 2'd0;
            pst        = ST_KEY;
        end else if (p_remaining == 64'd0) begin
            pst = ST_HDR0;
        end else begin
            p_key_pos = 2'd0;
            pst       = ST_PAYLOAD;
        end
    endfunction

    // Advance the model by one byte; return 1 when a payload byte comes out
    function automatic bit predict_unmask(input t_in_item it, output t_result res);
        t_parse_st  st;
        logic [7:0] kb;
        logic       last;
        res = '0;
        predict_unmask = 1'b0;
        st = it.frame_start ? ST_HDR0 : pst;
        case (st)
            ST_HDR1: begin
                p_masked    = it.data_byte[7];
                p_remaining = 64'd0;
                if (it.data_byte[6:0] == LEN_16BIT_CODE) begin
                    p_len_left = EXT_LEN_16_BYTES;
                    pst        = ST_EXTLEN;
                end else if (it.data_byte[6:0] == LEN_64BIT_CODE) begin
                    p_len_left = EXT_LEN_64_BYTES;
                    pst        = ST_EXTLEN;
                end else begin
                    p_len_left  = 4'd0;
                    p_remaining = 64'(it.data_byte[6:0]);
                    settle_length();
                end
            end
            ST_EXTLEN: begin
                p_remaining = {p_remaining[55:0], it.data_byte};
                p_len_left  = p_len_left - 4'd1;
                if (p_len_left == 4'd0) settle_length();
            end
            ST_KEY: begin
                p_key      = {p_key[23:0], it.data_byte};
                p_key_left = p_key_left - 3'd1;
                if (p_key_left == 3'd0) begin
                    p_key_pos = 2'd0;
                    pst = (p_remaining == 64'd0) ? ST_HDR0 : ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                kb = p_masked ? p_key[8 * (3 - p_key_pos) +: 8] : 8'h00;
                p_remaining = p_remaining - 64'd1;
                last = (p_remaining == 64'd0);
                p_key_pos = p_key_pos + 2'd1;
                if (last) pst = ST_HDR0;
                res.payload_byte  = it.data_byte ^ kb;
                res.frame_opcode  = p_opcode;
                res.frame_fin     = p_fin;
                res.last_of_frame = last;
                predict_unmask = 1'b1;
            end
            default: begin
                // header byte 0: FIN and opcode, RSV bits dropped
                p_fin       = it.data_byte[7];
                p_opcode    = it.data_byte[3:0];
                p_masked    = 1'b0;
                p_len_left  = 4'd0;
                p_remaining = 64'd0;
                p_key_left  = 3'd0;
                p_key_pos   = 2'd0;
                pst         = ST_HDR1;
            end
        endcase
    endfunction

    // Offer one byte, hold it until the request is taken, then predict
    task automatic send_byte(input logic [7:0] b, input logic fs);
        t_in_item it;
        t_result  res;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= b;
        in_if.frame_start <= fs;
        do @(posedge i_clk); while (!in_if.ready);
        it.data_byte   = b;
        it.frame_start = fs;
        if (predict_unmask(it, res)) pending_payload.push_back(res);
        bytes_sent++;
    endtask

    // Stop offering and wait until every expected payload byte has come out
    task automatic pause_sender();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_payload.size() != 0);
    endtask

    // Reserved opcode with RSV bits, byte extremes, then an empty frame back to back
    task automatic test_unmasked_and_empty();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Non-minimal 16-bit length with a key, then a masked empty control frame
    task automatic test_masked_ext16();
        send_byte(8'h81, 1'b0);
        send_byte({1'b1, LEN_16BIT_CODE}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h8A, 1'b0);
        send_byte(8'h80, 1'b0);
        repeat (4) send_byte(8'hC3, 1'b0);
    endtask

    // 64-bit length with its top bit set, abandoned by a restart mid-payload
    task automatic test_ext64_restart();
        send_byte(8'h02, 1'b1);
        send_byte({1'b0, LEN_64BIT_CODE}, 1'b0);
        send_byte(8'h80, 1'b0);
        repeat (7) send_byte(8'h00, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    // Hold the receiver off while a long masked frame keeps coming
    task automatic test_backpressure();
        int i;
        hold_left = 300;
        send_byte(8'h82, 1'b1);
        send_byte({1'b1, LEN_16BIT_CODE}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'd200, 1'b0);
        for (i = 3; i >= 0; i--) send_byte(8'(32'h1E2D3C4B >> (8 * i)), 1'b0);
        repeat (200) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    // One frame with random content, or a burst of noise
    task automatic send_random_frame();
        int unsigned pick;
        int unsigned plen;
        int unsigned nsend;
        int          ext_n;
        int          i;
        logic [7:0]  hdr0;
        logic        masked;
        logic        fs;
        logic [6:0]  len7;
        logic [63:0] ext;
        logic [31:0] key;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            need_restart = 1'b1;
            return;
        end
        fs = need_restart ? 1'b1 : 1'($urandom_range(1));
        need_restart = 1'b0;
        hdr0   = 8'($urandom_range(255));
        masked = 1'($urandom_range(1));
        key    = $urandom;
        ext_n  = 0;
        ext    = 64'd0;
        pick   = $urandom_range(99);
        if (pick < 65) begin
            len7 = 7'($urandom_range(0, 12));
            plen = 32'(len7);
            nsend = plen;
        end else if (pick < 75) begin
            len7 = 7'($urandom_range(13, 125));
            plen = 32'(len7);
            nsend = plen;
        end else if (pick < 88) begin
            len7  = LEN_16BIT_CODE;
            ext_n = int'(EXT_LEN_16_BYTES);
            plen  = $urandom_range(0, 140);
            ext   = 64'(plen);
            nsend = plen;
        end else if (pick < 96) begin
            len7  = LEN_64BIT_CODE;
            ext_n = int'(EXT_LEN_64_BYTES);
            plen  = $urandom_range(0, 40);
            ext   = 64'(plen);
            nsend = plen;
        end else begin
            // oversized length: send a few bytes and abandon the frame
            len7  = $urandom_range(1) ? LEN_16BIT_CODE : LEN_64BIT_CODE;
            ext_n = (len7 == LEN_16BIT_CODE) ? int'(EXT_LEN_16_BYTES)
                                             : int'(EXT_LEN_64_BYTES);
            ext   = {$urandom, $urandom} | (64'd1 << (8 * ext_n - 1));
            plen  = 0;
            nsend = $urandom_range(0, 10);
            need_restart = 1'b1;
        end
        // occasionally cut a normal frame short
        if (!need_restart && plen > 1 && $urandom_range(99) < 4) begin
            nsend = $urandom_range(plen - 1);
            need_restart = 1'b1;
        end
        send_byte(hdr0, fs);
        send_byte({masked, len7}, 1'b0);
        for (i = ext_n - 1; i >= 0; i--) send_byte(ext[8 * i +: 8], 1'b0);
        if (masked) begin
            for (i = 3; i >= 0; i--) send_byte(key[8 * i +: 8], 1'b0);
        end
        repeat (nsend) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic test_random(input int n_bytes);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes) send_random_frame();
    endtask

    // Receiver: long hold when asked, otherwise random stalls
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each delivered payload byte with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.payload_byte  = out_if.payload_byte;
            got.frame_opcode  = out_if.frame_opcode;
            got.frame_fin     = out_if.frame_fin;
            got.last_of_frame = out_if.last_of_frame;
            if (pending_payload.size() == 0) begin
                $display("%0t: unexpected payload byte %h op %h fin %b last %b", $time,
                         got.payload_byte, got.frame_opcode, got.frame_fin,
                         got.last_of_frame);
                mismatch_count++;
            end else begin
                want = pending_payload.pop_front();
                if (got !== want) begin
                    $display("%0t: expected byte %h op %h fin %b last %b, got %h %h %b %b",
                             $time, want.payload_byte, want.frame_opcode, want.frame_fin,
                             want.last_of_frame, got.payload_byte, got.frame_opcode,
                             got.frame_fin, got.last_of_frame);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        bytes_sent     = 0;
        hold_left      = 0;
        need_restart   = 1'b1;
        send_idle_pct  = 9;
        recv_idle_pct  = 63;
        pst         = ST_HDR0;
        p_opcode    = 4'd0;
        p_fin       = 1'b0;
        p_masked    = 1'b0;
        p_len_left  = 4'd0;
        p_remaining = 64'd0;
        p_key       = 32'd0;
        p_key_left  = 3'd0;
        p_key_pos   = 2'd0;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.data_byte   <= 8'h00;
        in_if.frame_start <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unmasked_and_empty();
        test_masked_ext16();
        test_ext64_restart();
        pause_sender();
        test_backpressure();
        pause_sender();
        test_random(550);
        pause_sender();

        send_idle_pct = 63;
        recv_idle_pct = 9;
        test_random(550);
        pause_sender();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(560);
        pause_sender();

        // let any stray output show before the verdict
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_payload.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
